@@ rtl/core/sdl_pkg.sv @@
// Shared types and codes for the sorted descending list.
// No dependencies; imported by sdl_cell and sorted_descending_list.
package sdl_pkg;

    localparam int VALUE_W     = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_READOUT = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op op;
        logic     found;
    } t_cell_ctl;

    // per-cell position relative to the fill level
    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_pos;

    typedef enum logic {
        FSM_IDLE    = 1'b0,
        FSM_READOUT = 1'b1
    } t_fsm;

endpackage

@@ rtl/core/sdl_cell.sv @@
// One storage cell of the sorted chain: holds an entry, compares it with the
// broadcast value and takes its own, a neighbor's or the new value. Uses sdl_pkg.
module sdl_cell (
    input  logic              i_clk,
    input  sdl_pkg::t_cell_ctl i_ctl,
    input  sdl_pkg::t_cell_pos i_pos,
    input  sdl_pkg::t_value   i_value,
    input  sdl_pkg::t_value   i_left_entry,
    input  logic              i_left_gt,
    input  sdl_pkg::t_value   i_right_entry,
    input  sdl_pkg::t_value   i_head_entry,
    output sdl_pkg::t_value   o_entry,
    output logic              o_gt,
    output logic              o_eq
);
    import sdl_pkg::*;

    t_value r_entry;
    t_value n_entry;

    // gt: stored entry is strictly greater than the value (value stays behind it)
    assign o_gt    = i_pos.occupied && (i_value < r_entry);
    assign o_eq    = i_pos.occupied && (i_value == r_entry);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_gt) begin
                    n_entry = i_left_gt ? i_value : i_left_entry;
                end
            end
            CELL_REMOVE: begin
                // sorted order: every cell at or past the first match has entry <= value
                if (i_ctl.found && !o_gt) begin
                    n_entry = i_right_entry;
                end
            end
            CELL_ROTATE: begin
                n_entry = i_pos.tail ? i_head_entry : i_right_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ rtl/core/sorted_descending_list.sv @@
// Top level of the sorted descending list: cell chain, fill count, readout
// sequencer and output register. Uses sdl_pkg and sdl_cell.
//
// Keeps up to CAPACITY signed 32-bit values, largest first, in a chain of
// cells that compare against the incoming value in parallel and shift by one
// place. Insert, remove and clear each give one beat. A readout of n entries
// holds off input until its n beats have been taken: the chain rotates by
// one cell per beat and cell zero feeds the output, so after n beats the
// order is restored. The output register lets a new item in while the
// previous beat is taken in the same cycle.
module sorted_descending_list #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sdl_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [sdl_pkg::VALUE_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sdl_pkg::STATUS_W-1:0]     o_status,
    output logic [sdl_pkg::COUNT_OUT_W-1:0]  o_entry_count,
    output logic signed [sdl_pkg::VALUE_W-1:0] o_entry_value,
    output logic                             o_last
);
    import sdl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    t_fsm               r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_o_valid, n_o_valid;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_o_count, n_o_count;
    t_value             r_o_value, n_o_value;
    logic               r_o_last, n_o_last;

    t_cell_ctl          w_ctl;
    t_cell_pos          w_pos [CAPACITY];
    t_value             w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_eq;
    logic               w_found;
    logic               w_out_free;
    logic               w_accept;
    logic               w_read_last;
    t_mode              w_mode;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;

    assign w_mode      = t_mode'(i_mode);
    assign w_found     = |w_eq;
    assign w_out_free  = !r_o_valid || !i_out_stall;
    assign o_in_stall  = (r_state != FSM_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_read_last = (r_idx == (r_count - ONE_C));

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_value w_left;
        logic   w_left_gt;
        t_value w_right;

        assign w_pos[k].occupied = CNT_W'(k) < r_count;
        assign w_pos[k].tail     = CNT_W'(k) == (r_count - ONE_C);

        if (k == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_gt = 1'b1;
        end else begin : g_body
            assign w_left    = w_entry[k-1];
            assign w_left_gt = w_gt[k-1];
        end

        if (k == CAPACITY - 1) begin : g_end
            assign w_right = w_entry[k];
        end else begin : g_mid
            assign w_right = w_entry[k+1];
        end

        sdl_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_pos         (w_pos[k]),
            .i_value       (i_value),
            .i_left_entry  (w_left),
            .i_left_gt     (w_left_gt),
            .i_right_entry (w_right),
            .i_head_entry  (w_entry[0]),
            .o_entry       (w_entry[k]),
            .o_gt          (w_gt[k]),
            .o_eq          (w_eq[k])
        );
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE: begin
                if (w_accept && (w_mode == MODE_READOUT) && (r_count != '0)) begin
                    n_state = FSM_READOUT;
                end
            end
            FSM_READOUT: begin
                if (w_out_free && w_read_last) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // ---------------- datapath control and result ----------------
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.found = w_found;
        n_count     = r_count;
        n_idx       = r_idx;
        n_o_valid   = r_o_valid && i_out_stall;
        n_status    = r_status;
        n_o_count   = r_o_count;
        n_o_value   = r_o_value;
        n_o_last    = r_o_last;

        unique case (r_state)
            FSM_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    n_o_value = '0;
                    n_o_last  = 1'b1;
                    n_status  = STATUS_OK;
                    n_o_valid = 1'b1;
                    unique case (w_mode)
                        MODE_INSERT: begin
                            if (r_count >= CAP_C) begin
                                n_status = STATUS_FULL;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + ONE_C;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = STATUS_EMPTY;
                            end else if (!w_found) begin
                                n_status = STATUS_NOT_FOUND;
                            end else begin
                                w_ctl.op = CELL_REMOVE;
                                n_count  = r_count - ONE_C;
                            end
                        end
                        MODE_CLEAR: begin
                            n_status = (r_count == '0) ? STATUS_EMPTY : STATUS_OK;
                            n_count  = '0;
                        end
                        MODE_READOUT: begin
                            if (r_count == '0) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                // beats come from the readout state
                                n_o_valid = 1'b0;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                    n_o_count = n_count;
                end
            end
            FSM_READOUT: begin
                if (w_out_free) begin
                    w_ctl.op  = CELL_ROTATE;
                    n_o_valid = 1'b1;
                    n_status  = STATUS_OK;
                    n_o_count = r_count;
                    n_o_value = w_entry[0];
                    n_o_last  = w_read_last;
                    n_idx     = r_idx + ONE_C;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FSM_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_o_count <= n_o_count;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
    end

    assign w_count_ext   = {{COUNT_OUT_W{1'b0}}, r_o_count};
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_status;
    assign o_entry_count = w_count_ext[COUNT_OUT_W-1:0];
    assign o_entry_value = r_o_value;
    assign o_last        = r_o_last;

endmodule
